@@ rtl/status_led_animator_defines.svh @@
// ---------------------------------------------------------------------------
// status_led_animator_defines: assertion macros used only by sla_checker among the checker files
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_ANIMATOR_DEFINES_SVH
`define STATUS_LED_ANIMATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sla_pkg.sv @@
// ---------------------------------------------------------------------------
// sla_pkg: shared types, codes and tables of the status LED animator
// ---------------------------------------------------------------------------
package sla_pkg;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_SOLID   = 3'd1,
        MODE_BREATH  = 3'd2,
        MODE_PULSE   = 3'd3,
        MODE_RAINBOW = 3'd4
    } mode_t;

    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned BRIGHT_W = 8;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = COLOR_W + BRIGHT_W;

    localparam logic [IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASE_COLOR   = 3'd1;
    localparam logic [IDX_W-1:0] REG_BASE_BRIGHT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BREATH_PER   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PULSE_PER    = 3'd4;
    localparam logic [IDX_W-1:0] REG_RAINBOW_PER  = 3'd5;

    localparam mode_t                RST_MODE        = MODE_SOLID;
    localparam logic [COLOR_W-1:0]   RST_BASE_COLOR  = 24'h002000;
    localparam logic [BRIGHT_W-1:0]  RST_BASE_BRIGHT = 8'd50;
    localparam logic [TICK_W-1:0]    RST_BREATH_PER  = 16'd20;
    localparam logic [TICK_W-1:0]    RST_PULSE_PER   = 16'd50;
    localparam logic [TICK_W-1:0]    RST_RAINBOW_PER = 16'd30;

    // brightness = (base * RECIP_TAB[pct]) >> RECIP_SHIFT, equals base*pct/100
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned RECIP_W     = 18;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef recip_t recip_tab_t [256];

    function automatic recip_tab_t build_recip();
        recip_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = RECIP_W'((i * (1 << RECIP_SHIFT) + 99) / 100);
        end
        return t;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip();

    // three-segment color wheel, packed red in the top byte
    function automatic logic [COLOR_W-1:0] wheel_color(logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] up;
        logic [7:0] dn;
        logic [COLOR_W-1:0] c;
        if (pos < 8'd85) begin
            p = pos;
        end else if (pos < 8'd170) begin
            p = pos - 8'd85;
        end else begin
            p = pos - 8'd170;
        end
        up = p + {p[6:0], 1'b0};
        dn = 8'd255 - up;
        if (pos < 8'd85) begin
            c = {up, dn, 8'd0};
        end else if (pos < 8'd170) begin
            c = {dn, 8'd0, up};
        end else begin
            c = {8'd0, up, dn};
        end
        return c;
    endfunction

endpackage

@@ rtl/status_led_animator.sv @@
// ---------------------------------------------------------------------------
// status_led_animator: off / solid / breathing / pulse / rainbow LED animator
// A request passes through the input register, then the result register, before its result is valid.
// Throughput: one request per cycle; s_tready drops only while both regs stall.
// Reset (aresetn low, synchronous): registers back to defaults, pipeline empty.
// ---------------------------------------------------------------------------
module status_led_animator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sla_pkg::S_DATA_W-1:0]  s_tdata,    // [0] advance, rest zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sla_pkg::M_DATA_W-1:0]  m_tdata,    // [23:0] pixel_color, [31:24] brightness
    output logic [0:0]                    m_tuser,    // [0] stepped
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sla_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sla_pkg::CFG_W-1:0]     cfg_data
);

    // configuration
    sla_pkg::mode_t                  mode_reg;
    logic [sla_pkg::COLOR_W-1:0]     base_color_reg;
    logic [sla_pkg::BRIGHT_W-1:0]    base_bright_reg;
    logic [sla_pkg::TICK_W-1:0]      breath_per_reg;
    logic [sla_pkg::TICK_W-1:0]      pulse_per_reg;
    logic [sla_pkg::TICK_W-1:0]      rainbow_per_reg;

    // animation state
    logic [sla_pkg::LEVEL_W-1:0]     level_reg,   level_next;
    logic                            rising_reg,  rising_next;
    logic [sla_pkg::TICK_W-1:0]      elapsed_reg, elapsed_next;
    logic [sla_pkg::BRIGHT_W-1:0]    hbright_reg, hbright_next;
    logic [sla_pkg::COLOR_W-1:0]     hcolor_reg,  hcolor_next;

    // pipeline
    logic                            in_valid_reg;
    logic                            in_adv_reg;
    logic                            m_valid_reg;
    logic [sla_pkg::COLOR_W-1:0]     m_color_reg;
    logic [sla_pkg::BRIGHT_W-1:0]    m_bright_reg;
    logic                            m_step_reg;

    logic                            out_free;
    logic                            fire;
    logic                            s_acc;
    logic                            cfg_wr;

    logic                            animated;
    logic [sla_pkg::TICK_W-1:0]      period;
    logic [sla_pkg::TICK_W-1:0]      elapsed_inc;
    logic                            do_step;
    logic [sla_pkg::LEVEL_W-1:0]     lv_up;
    logic [sla_pkg::LEVEL_W-1:0]     lv_dn;
    logic [sla_pkg::LEVEL_W:0]       lv_sum;
    logic [sla_pkg::LEVEL_W-1:0]     lv_pulse;
    logic [6:0]                      lv_dev;
    logic [sla_pkg::LEVEL_W-1:0]     pct;
    logic [sla_pkg::RECIP_W+sla_pkg::BRIGHT_W-1:0] prod;
    logic [sla_pkg::BRIGHT_W+1:0]    scaled;
    logic [sla_pkg::BRIGHT_W-1:0]    scaled_sat;
    logic [sla_pkg::COLOR_W-1:0]     pixel;

    assign out_free  = !m_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_bright_reg, m_color_reg};
    assign m_tuser   = m_step_reg;

    always_comb begin
        animated     = 1'b0;
        period       = '0;
        level_next   = level_reg;
        rising_next  = rising_reg;
        hbright_next = hbright_reg;
        hcolor_next  = hcolor_reg;
        pct          = '0;
        lv_up        = level_reg + 8'd2;
        lv_dn        = level_reg - 8'd2;
        lv_sum       = {1'b0, level_reg} + 9'd5;

        unique case (mode_reg)
            sla_pkg::MODE_BREATH: begin
                animated = 1'b1;
                period   = breath_per_reg;
            end
            sla_pkg::MODE_PULSE: begin
                animated = 1'b1;
                period   = pulse_per_reg;
            end
            sla_pkg::MODE_RAINBOW: begin
                animated = 1'b1;
                period   = rainbow_per_reg;
            end
            default: begin
                animated = 1'b0;
            end
        endcase

        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 16'd1 : elapsed_reg;
        do_step     = in_adv_reg && animated && (elapsed_inc > period);
        if (!in_adv_reg) begin
            elapsed_next = elapsed_reg;
        end else if (do_step) begin
            elapsed_next = '0;
        end else begin
            elapsed_next = elapsed_inc;
        end

        priority if (lv_sum >= 9'd200) begin
            lv_pulse = 8'(lv_sum - 9'd200);
        end else if (lv_sum >= 9'd100) begin
            lv_pulse = 8'(lv_sum - 9'd100);
        end else begin
            lv_pulse = lv_sum[7:0];
        end
        lv_dev = (lv_pulse > 8'd50) ? 7'(lv_pulse - 8'd50) : 7'(8'd50 - lv_pulse);

        if (mode_reg == sla_pkg::MODE_BREATH) begin
            if (rising_reg) begin
                if (lv_up >= 8'd100) begin
                    level_next  = 8'd100;
                    rising_next = 1'b0;
                end else begin
                    level_next  = lv_up;
                end
            end else begin
                if (lv_dn <= 8'd10) begin
                    level_next  = 8'd10;
                    rising_next = 1'b1;
                end else begin
                    level_next  = lv_dn;
                end
            end
            pct = level_next;
        end else begin
            level_next = (mode_reg == sla_pkg::MODE_PULSE) ? lv_pulse : level_reg + 8'd1;
            pct        = {lv_dev, 1'b0};
        end

        prod       = base_bright_reg * sla_pkg::RECIP_TAB[pct];
        scaled     = prod[sla_pkg::RECIP_SHIFT +: sla_pkg::BRIGHT_W+2];
        scaled_sat = (scaled > 10'd255) ? 8'd255 : scaled[sla_pkg::BRIGHT_W-1:0];

        if (do_step) begin
            if (mode_reg == sla_pkg::MODE_RAINBOW) begin
                hcolor_next = sla_pkg::wheel_color(level_next);
            end else begin
                hbright_next = scaled_sat;
                hcolor_next  = base_color_reg;
            end
        end else begin
            level_next  = level_reg;
            rising_next = rising_reg;
        end

        if (mode_reg == sla_pkg::MODE_SOLID) begin
            hcolor_next  = base_color_reg;
            hbright_next = base_bright_reg;
        end

        unique case (mode_reg)
            sla_pkg::MODE_SOLID,
            sla_pkg::MODE_BREATH,
            sla_pkg::MODE_PULSE,
            sla_pkg::MODE_RAINBOW: pixel = hcolor_next;
            default:               pixel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= sla_pkg::RST_MODE;
            base_color_reg  <= sla_pkg::RST_BASE_COLOR;
            base_bright_reg <= sla_pkg::RST_BASE_BRIGHT;
            breath_per_reg  <= sla_pkg::RST_BREATH_PER;
            pulse_per_reg   <= sla_pkg::RST_PULSE_PER;
            rainbow_per_reg <= sla_pkg::RST_RAINBOW_PER;
            level_reg       <= '0;
            rising_reg      <= 1'b1;
            elapsed_reg     <= '0;
            hbright_reg     <= sla_pkg::RST_BASE_BRIGHT;
            hcolor_reg      <= sla_pkg::RST_BASE_COLOR;
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (fire) begin
                level_reg   <= level_next;
                rising_reg  <= rising_next;
                elapsed_reg <= elapsed_next;
                hbright_reg <= hbright_next;
                hcolor_reg  <= hcolor_next;
            end
            if (cfg_wr) begin
                unique case (cfg_index)
                    sla_pkg::REG_MODE: begin
                        mode_reg   <= sla_pkg::mode_t'(cfg_data[sla_pkg::IDX_W-1:0]);
                        level_reg  <= '0;
                        rising_reg <= 1'b1;
                    end
                    sla_pkg::REG_BASE_COLOR:  base_color_reg  <= cfg_data;
                    sla_pkg::REG_BASE_BRIGHT: base_bright_reg <= cfg_data[sla_pkg::BRIGHT_W-1:0];
                    sla_pkg::REG_BREATH_PER:  breath_per_reg  <= cfg_data[sla_pkg::TICK_W-1:0];
                    sla_pkg::REG_PULSE_PER:   pulse_per_reg   <= cfg_data[sla_pkg::TICK_W-1:0];
                    sla_pkg::REG_RAINBOW_PER: rainbow_per_reg <= cfg_data[sla_pkg::TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_acc) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_adv_reg <= s_tdata[0];
        end
        if (fire) begin
            m_color_reg  <= pixel;
            m_bright_reg <= hbright_next;
            m_step_reg   <= do_step;
        end
    end

endmodule

@@ rtl/sla_checker.sv @@
// ---------------------------------------------------------------------------
// sla_checker: port-level checks of the status LED animator
// ---------------------------------------------------------------------------
`include "status_led_animator_defines.svh"

module sla_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sla_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          cfg_ready
);

    // stalled result holds
    `SLA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // input side only backs up when the result side is full and stalled
    `SLA_ASSERT_SAME(a_bp_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "s_tready low without output stall")

    // a fresh result traces back to an accepted request, through the input reg and the result reg
    `SLA_ASSERT_SAME(a_out_origin, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without request")

    // configuration writes are never refused
    `SLA_ASSERT_SAME(a_cfg_ready, aclk, aresetn, 1'b1, cfg_ready, "cfg_ready low")

endmodule

bind status_led_animator sla_checker u_sla_checker (.*);

@@ verif/led_output_checker.sv @@
// ---------------------------------------------------------------------------
// led_output_checker: predicts and checks the LED animator's output stream
// Tracks register writes and tick requests, keeps its own copy of the
// animation state, and compares each result against the oldest prediction.
// ---------------------------------------------------------------------------
module led_output_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sla_pkg::S_DATA_W-1:0]  s_tdata,    // [0] advance
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sla_pkg::M_DATA_W-1:0]  m_tdata,    // [23:0] pixel_color, [31:24] brightness
    input  logic [0:0]                    m_tuser,    // [0] stepped
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sla_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sla_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatch_count,
    output int                            frames_pending
);

    typedef struct packed {
        logic [23:0] pixel;
        logic [7:0]  bright;
        logic        stepped;
    } led_frame_t;

    led_frame_t  expected_frames[$];

    logic [2:0]  cur_mode;
    logic [23:0] base_color;
    logic [7:0]  base_bright;
    logic [15:0] breath_per;
    logic [15:0] pulse_per;
    logic [15:0] rainbow_per;
    logic [7:0]  level;
    logic        rising;
    logic [15:0] elapsed;
    logic [7:0]  held_bright;
    logic [23:0] held_color;

    function automatic logic [7:0] scaled_brightness(input int unsigned pct);
        int unsigned v;
        v = 32'(base_bright) * pct / 100;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        int unsigned p;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        p = 32'(pos);
        if (p < 85) begin
            r = 8'(p * 3);
            g = 8'(255 - p * 3);
            b = 8'd0;
        end else if (p < 170) begin
            p = p - 85;
            r = 8'(255 - p * 3);
            g = 8'd0;
            b = 8'(p * 3);
        end else begin
            p = p - 170;
            r = 8'd0;
            g = 8'(p * 3);
            b = 8'(255 - p * 3);
        end
        return {r, g, b};
    endfunction

    task automatic advance_animation(input logic tick, output led_frame_t res);
        int unsigned period;
        int unsigned dev;
        logic        animated;
        logic        step_now;
        period   = 0;
        animated = 1'b0;
        step_now = 1'b0;
        case (cur_mode)
            sla_pkg::MODE_BREATH: begin
                period   = 32'(breath_per);
                animated = 1'b1;
            end
            sla_pkg::MODE_PULSE: begin
                period   = 32'(pulse_per);
                animated = 1'b1;
            end
            sla_pkg::MODE_RAINBOW: begin
                period   = 32'(rainbow_per);
                animated = 1'b1;
            end
            default: ;
        endcase
        if (tick) begin
            if (elapsed != 16'hFFFF) begin
                elapsed = elapsed + 16'd1;
            end
            if (animated && 32'(elapsed) > period) begin
                elapsed  = '0;
                step_now = 1'b1;
                if (cur_mode == sla_pkg::MODE_BREATH) begin
                    if (rising) begin
                        level = level + 8'd2;
                        if (level >= 8'd100) begin
                            level  = 8'd100;
                            rising = 1'b0;
                        end
                    end else begin
                        level = level - 8'd2;
                        if (level <= 8'd10) begin
                            level  = 8'd10;
                            rising = 1'b1;
                        end
                    end
                    held_bright = scaled_brightness(32'(level));
                    held_color  = base_color;
                end else if (cur_mode == sla_pkg::MODE_PULSE) begin
                    level       = 8'((32'(level) + 5) % 100);
                    dev         = (level > 8'd50) ? 32'(level) - 50 : 50 - 32'(level);
                    held_bright = scaled_brightness(dev * 2);
                    held_color  = base_color;
                end else begin
                    level      = level + 8'd1;
                    held_color = wheel_rgb(level);
                end
            end
        end
        if (cur_mode == sla_pkg::MODE_SOLID) begin
            held_color  = base_color;
            held_bright = base_bright;
        end
        res.pixel   = (cur_mode >= sla_pkg::MODE_SOLID && cur_mode <= sla_pkg::MODE_RAINBOW)
                      ? held_color : 24'd0;
        res.bright  = held_bright;
        res.stepped = step_now;
    endtask

    always @(posedge aclk) begin
        led_frame_t want;
        led_frame_t fresh;
        if (!aresetn) begin
            cur_mode    = sla_pkg::MODE_SOLID;
            base_color  = 24'h002000;
            base_bright = 8'd50;
            breath_per  = 16'd20;
            pulse_per   = 16'd50;
            rainbow_per = 16'd30;
            level       = '0;
            rising      = 1'b1;
            elapsed     = '0;
            held_bright = 8'd50;
            held_color  = 24'h002000;
            expected_frames.delete();
            frames_pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: pixel_color %06h brightness %0d stepped %0d",
                           m_tdata[23:0], m_tdata[31:24], m_tuser[0]);
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tdata[23:0] !== want.pixel) begin
                        $error("pixel_color: expected %06h, got %06h", want.pixel, m_tdata[23:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[31:24] !== want.bright) begin
                        $error("brightness: expected %0d, got %0d", want.bright, m_tdata[31:24]);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.stepped) begin
                        $error("stepped: expected %0d, got %0d", want.stepped, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sla_pkg::REG_MODE: begin
                        cur_mode = cfg_data[2:0];
                        level    = '0;
                        rising   = 1'b1;
                    end
                    sla_pkg::REG_BASE_COLOR:  base_color  = cfg_data[23:0];
                    sla_pkg::REG_BASE_BRIGHT: base_bright = cfg_data[7:0];
                    sla_pkg::REG_BREATH_PER:  breath_per  = cfg_data[15:0];
                    sla_pkg::REG_PULSE_PER:   pulse_per   = cfg_data[15:0];
                    sla_pkg::REG_RAINBOW_PER: rainbow_per = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_animation(s_tdata[0], fresh);
                expected_frames.push_back(fresh);
            end
            frames_pending = expected_frames.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the status LED animator
// Drives directed and random tick requests across mode and register settings,
// including the largest tick periods, with random gaps and back-pressure;
// a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;

    localparam logic [sla_pkg::IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [sla_pkg::IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [sla_pkg::S_DATA_W-1:0]  s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [sla_pkg::M_DATA_W-1:0]  m_tdata;
    logic [0:0]                    m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sla_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [sla_pkg::CFG_W-1:0]     cfg_data  = '0;

    int          mismatch_count;
    int          frames_pending;
    logic        gap_en   = 1'b0;
    logic        stall_en = 1'b0;
    int unsigned rand_ticks;

    always #4 aclk = ~aclk;

    status_led_animator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_output_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending)
    );

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_en && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // called at a falling edge; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [sla_pkg::IDX_W-1:0] idx,
                             input logic [sla_pkg::CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_tick(input logic adv);
        if (gap_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(sla_pkg::S_DATA_W-1){1'b0}}, adv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_tvalid  = 1'b0;
        cfg_valid = 1'b0;
        while (frames_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [2:0] pick_mode();
        case ($urandom_range(0, 11))
            0:         return sla_pkg::MODE_OFF;
            1:         return sla_pkg::MODE_SOLID;
            2:         return 3'($urandom_range(5, 7));
            3, 4, 5:   return sla_pkg::MODE_BREATH;
            6, 7, 8:   return sla_pkg::MODE_PULSE;
            default:   return sla_pkg::MODE_RAINBOW;
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 15))
            0:       return 16'hFFFF;
            1:       return 16'd0;
            2, 3, 4: return 16'($urandom_range(4, 40));
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [7:0] pick_bright();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // upper bits beyond each register's width carry junk
    task automatic reshuffle_settings();
        logic [23:0] junk;
        junk = 24'($urandom);
        if ($urandom_range(0, 2) == 0)
            write_reg(sla_pkg::REG_BASE_COLOR, 24'($urandom));
        if ($urandom_range(0, 2) == 0)
            write_reg(sla_pkg::REG_BASE_BRIGHT, {junk[23:8], pick_bright()});
        if ($urandom_range(0, 2) == 0)
            write_reg(sla_pkg::REG_BREATH_PER, {junk[23:16], pick_period()});
        if ($urandom_range(0, 2) == 0)
            write_reg(sla_pkg::REG_PULSE_PER, {junk[23:16], pick_period()});
        if ($urandom_range(0, 2) == 0)
            write_reg(sla_pkg::REG_RAINBOW_PER, {junk[23:16], pick_period()});
        if ($urandom_range(0, 1) == 0)
            write_reg(sla_pkg::REG_MODE, {junk[23:3], pick_mode()});
        cfg_valid = 1'b0;
    endtask

    initial begin
        int unsigned run_len;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        gap_en   = 1'b1;
        stall_en = 1'b1;

        // reset settings: solid green
        send_tick(1'b1);
        send_tick(1'b0);
        quiesce();

        // breathing at full scale, stepping on every advance tick
        write_reg(sla_pkg::REG_BASE_COLOR, 24'hFFFFFF);
        write_reg(sla_pkg::REG_BASE_BRIGHT, 24'hFFFFFF);
        write_reg(sla_pkg::REG_BREATH_PER, 24'h000000);
        write_reg(sla_pkg::REG_MODE, {21'h1FFFFF, sla_pkg::MODE_BREATH});
        cfg_valid = 1'b0;
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        quiesce();

        write_reg(sla_pkg::REG_PULSE_PER, 24'hFF0000);
        write_reg(sla_pkg::REG_MODE, 24'(sla_pkg::MODE_PULSE));
        cfg_valid = 1'b0;
        repeat (3) send_tick(1'b1);
        quiesce();

        write_reg(sla_pkg::REG_RAINBOW_PER, 24'h000000);
        write_reg(sla_pkg::REG_MODE, 24'(sla_pkg::MODE_RAINBOW));
        cfg_valid = 1'b0;
        repeat (3) send_tick(1'b1);
        quiesce();

        // off, unused mode codes 7 and 5, and writes to the unmapped register indices
        write_reg(sla_pkg::REG_MODE, 24'(sla_pkg::MODE_OFF));
        cfg_valid = 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        quiesce();
        write_reg(REG_UNMAPPED_LO, 24'hFFFFFF);
        write_reg(REG_UNMAPPED_HI, 24'hFFFFFF);
        write_reg(sla_pkg::REG_MODE, 24'd7);
        cfg_valid = 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        quiesce();
        write_reg(sla_pkg::REG_MODE, 24'd5);
        cfg_valid = 1'b0;
        send_tick(1'b1);
        quiesce();

        write_reg(sla_pkg::REG_BASE_COLOR, 24'h000000);
        write_reg(sla_pkg::REG_BASE_BRIGHT, 24'h000000);
        write_reg(sla_pkg::REG_MODE, 24'(sla_pkg::MODE_SOLID));
        cfg_valid = 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        quiesce();

        // ticks in solid mode, then probe the largest periods
        gap_en   = 1'b0;
        stall_en = 1'b0;
        write_reg(sla_pkg::REG_BASE_COLOR, 24'h123456);
        write_reg(sla_pkg::REG_BASE_BRIGHT, 24'd200);
        cfg_valid = 1'b0;
        repeat (40) send_tick(1'b1);
        quiesce();
        write_reg(sla_pkg::REG_RAINBOW_PER, 24'h00FFFF);
        write_reg(sla_pkg::REG_MODE, 24'(sla_pkg::MODE_RAINBOW));
        cfg_valid = 1'b0;
        repeat (4) send_tick(1'b1);
        quiesce();
        write_reg(sla_pkg::REG_RAINBOW_PER, 24'h00FFFE);
        cfg_valid = 1'b0;
        repeat (2) send_tick(1'b1);
        quiesce();

        // random phases
        rand_ticks = 0;
        while (rand_ticks < 1060) begin
            if (rand_ticks >= 880) begin
                gap_en   = 1'b0;
                stall_en = 1'b0;
            end else begin
                gap_en   = 1'($urandom_range(0, 1));
                stall_en = 1'($urandom_range(0, 1));
            end
            reshuffle_settings();
            run_len = $urandom_range(10, 90);
            repeat (run_len) send_tick($urandom_range(0, 3) != 0);
            rand_ticks += run_len;
            quiesce();
        end

        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
